>>> rtl/core/single_wire_bus_master_defines.svh
// ----------------------------------------------------------------------------
// single-wire bus master assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_BUS_MASTER_DEFINES_SVH
`define SINGLE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWB_ASSERT_IMP(lbl, ante, cons, msg)
`define SWB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/swb_pkg.sv
// ----------------------------------------------------------------------------
// swb_pkg
// shared types and constants of the single-wire bus master
// ----------------------------------------------------------------------------
package swb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd5;

  typedef struct packed {
    logic       start_rst;
    logic       start_wr;
    logic       start_rd;
    logic [7:0] write_data;
    logic       bus_level;
  } swb_op_t;

  typedef struct packed {
    logic [11:0] reset_low_ticks;
    logic [11:0] presence_wait_ticks;
    logic [7:0]  slot_start_ticks;
    logic [7:0]  read_sample_ticks;
    logic [11:0] slot_ticks;
    logic [7:0]  recovery_ticks;
  } swb_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_byte;
  } swb_res_t;

endpackage

>>> rtl/core/swb_in_if.sv
// ----------------------------------------------------------------------------
// swb_in_if
// tick channel into the bus master: command, write byte and line level
// ----------------------------------------------------------------------------
interface swb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] write_data;
  logic       bus_level;

  modport source (output valid, output command, output write_data, output bus_level,
                  input ready);
  modport sink (input valid, input command, input write_data, input bus_level,
                output ready);
endinterface

>>> rtl/core/swb_out_if.sv
// ----------------------------------------------------------------------------
// swb_out_if
// result channel of the bus master, one item per tick
// ----------------------------------------------------------------------------
interface swb_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       no_presence;
  logic [7:0] read_byte;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output no_presence, output read_byte, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input no_presence, input read_byte, output ready);
endinterface

>>> rtl/core/swb_front.sv
// ----------------------------------------------------------------------------
// swb_front
// accepts ticks, decodes the start command and queues them for the back end
// ----------------------------------------------------------------------------
`include "single_wire_bus_master_defines.svh"

module swb_front
  import swb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  swb_in_if.sink     in_ch,
  output swb_op_t    head_op,
  output logic       head_valid,
  input  logic       head_pop
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  swb_op_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;
  swb_op_t            op;

  // decode
  always_comb begin
    op            = '0;
    op.start_rst  = (in_ch.command == CMD_RESET);
    op.start_wr   = (in_ch.command == CMD_WRITE);
    op.start_rd   = (in_ch.command == CMD_READ);
    op.write_data = in_ch.write_data;
    op.bus_level  = in_ch.bus_level;
  end

  assign in_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (cnt_r != '0);
  assign pop         = head_pop && head_valid;
  assign head_op     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op;
    end
  end

  `SWB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count out of range")
  `SWB_ASSERT_NEXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - CNT_W'(1), "pop lost")

endmodule

>>> rtl/core/swb_back.sv
// ----------------------------------------------------------------------------
// swb_back
// bus timing sequencer: one queued tick per cycle, while the result is free or taken, into a registered result
// ----------------------------------------------------------------------------
`include "single_wire_bus_master_defines.svh"

module swb_back
  import swb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  swb_cfg_t   cfg,
  input  swb_op_t    head_op,
  input  logic       head_valid,
  output logic       head_pop,
  swb_out_if.source  out_ch
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REL  = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HOLD  = 4'd5;
  localparam logic [3:0] PH_WR_REC   = 4'd6;
  localparam logic [3:0] PH_RD_LOW   = 4'd7;
  localparam logic [3:0] PH_RD_WAIT  = 4'd8;
  localparam logic [3:0] PH_RD_HOLD  = 4'd9;
  localparam logic [3:0] PH_RD_REC   = 4'd10;

  logic [3:0]  phase_r, phase_nxt;
  logic [11:0] tc_r, tc_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        pres_r, pres_nxt;
  logic        out_valid_r;
  swb_res_t    res_r, res_nxt;

  logic [3:0]  e_phase;
  logic [11:0] e_tc;
  logic [2:0]  e_bi;
  logic [7:0]  e_shift;
  logic [11:0] len_sel, tc_inc, tc_cnt;
  logic        cnt_end, drive, done, advance, level;

  assign advance  = head_valid && (!out_valid_r || out_ch.ready);
  assign head_pop = advance;
  assign level    = head_op.bus_level;

  always_comb begin
    e_phase = phase_r;
    e_tc    = tc_r;
    e_bi    = bi_r;
    e_shift = shift_r;
    if (phase_r == PH_IDLE) begin
      priority if (head_op.start_rst) begin
        e_phase = PH_RST_LOW;
        e_tc    = '0;
        e_bi    = '0;
      end else if (head_op.start_wr) begin
        e_phase = PH_WR_LOW;
        e_tc    = '0;
        e_bi    = '0;
        e_shift = head_op.write_data;
      end else if (head_op.start_rd) begin
        e_phase = PH_RD_LOW;
        e_tc    = '0;
        e_bi    = '0;
        e_shift = '0;
      end else begin
      end
    end

    unique case (e_phase)
      PH_RST_LOW:             len_sel = cfg.reset_low_ticks;
      PH_RST_WAIT:            len_sel = cfg.presence_wait_ticks;
      PH_WR_LOW, PH_RD_LOW:   len_sel = {4'd0, cfg.slot_start_ticks};
      PH_RD_WAIT:             len_sel = {4'd0, cfg.read_sample_ticks};
      PH_WR_HOLD, PH_RD_HOLD: len_sel = cfg.slot_ticks;
      PH_WR_REC, PH_RD_REC:   len_sel = {4'd0, cfg.recovery_ticks};
      default:                len_sel = '0;
    endcase

    tc_inc  = e_tc + 12'd1;
    cnt_end = (tc_inc >= len_sel);
    tc_cnt  = cnt_end ? '0 : tc_inc;

    phase_nxt = e_phase;
    tc_nxt    = e_tc;
    bi_nxt    = e_bi;
    shift_nxt = e_shift;
    pres_nxt  = pres_r;
    drive     = 1'b0;
    done      = 1'b0;

    unique case (e_phase)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        drive  = 1'b1;
        tc_nxt = tc_cnt;
        if (cnt_end) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          pres_nxt = level;
          if (level) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_RST_REL;
          end
        end
      end
      PH_RST_REL: begin
        if (level) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive  = 1'b1;
        tc_nxt = tc_cnt;
        if (cnt_end) phase_nxt = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        drive  = !e_shift[0];
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          shift_nxt = {1'b0, e_shift[7:1]};
          if (e_bi == '1) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_WR_REC;
          end
        end
      end
      PH_WR_REC: begin
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          bi_nxt    = e_bi + 3'd1;
          phase_nxt = PH_WR_LOW;
        end
      end
      PH_RD_LOW: begin
        drive  = 1'b1;
        tc_nxt = tc_cnt;
        if (cnt_end) phase_nxt = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          shift_nxt = {level, e_shift[7:1]};
          phase_nxt = PH_RD_HOLD;
        end
      end
      PH_RD_HOLD: begin
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          if (e_bi == '1) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_RD_REC;
          end
        end
      end
      PH_RD_REC: begin
        tc_nxt = tc_cnt;
        if (cnt_end) begin
          bi_nxt    = e_bi + 3'd1;
          phase_nxt = PH_RD_LOW;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tc_nxt    = '0;
      end
    endcase

    res_nxt.drive_low   = drive;
    res_nxt.busy_res    = (phase_nxt != PH_IDLE);
    res_nxt.done_res    = done;
    res_nxt.no_presence = pres_nxt;
    res_nxt.read_byte   = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tc_r        <= '0;
      bi_r        <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r     <= phase_nxt;
        tc_r        <= tc_nxt;
        bi_r        <= bi_nxt;
        shift_r     <= shift_nxt;
        pres_r      <= pres_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_low   = res_r.drive_low;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.no_presence = res_r.no_presence;
  assign out_ch.read_byte   = res_r.read_byte;

  `SWB_ASSERT_IMP(a_idle_count_clear, phase_r == PH_IDLE, tc_r == '0, "tick count left in idle")
  `SWB_ASSERT_IMP(a_done_not_busy, out_valid_r && res_r.done_res, !res_r.busy_res,
                  "done item still busy")
  `SWB_ASSERT_NEXT(a_state_holds, !advance,
                   $stable(phase_r) && $stable(tc_r) && $stable(bi_r) && $stable(shift_r),
                   "sequencer moved without an item")

endmodule

>>> rtl/core/single_wire_bus_master.sv
// ----------------------------------------------------------------------------
// single_wire_bus_master
// open-drain single-wire bus master, timed by one input item per bus tick
// ----------------------------------------------------------------------------
// Each input item is one tick: the sampled line level plus an optional start
// command (bus reset with presence detect, write byte, read byte, lsb first).
// Every accepted item gives exactly one result item telling whether to pull
// the line low on that tick, plus busy, done, presence and the shift byte.
// An item is taken every clock cycle while the queue has room: the decoder and
// a small queue feed the timing sequencer, which handles one queued tick per
// cycle into the output register while it is free or being read. Commands that
// arrive while an operation runs are ignored. The user writes timing registers
// through the cfg port while the block is idle; the block does not enforce it.
`include "single_wire_bus_master_defines.svh"

module single_wire_bus_master
  import swb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  swb_in_if.sink                in_ch,
  swb_out_if.source             out_ch
);

  swb_cfg_t cfg_r;
  swb_op_t  head_op;
  logic     head_valid;
  logic     head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= 12'd600;
      cfg_r.presence_wait_ticks <= 12'd60;
      cfg_r.slot_start_ticks    <= 8'd2;
      cfg_r.read_sample_ticks   <= 8'd2;
      cfg_r.slot_ticks          <= 12'd60;
      cfg_r.recovery_ticks      <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= cfg_wdata;
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= cfg_wdata;
        REG_SLOT_START:    cfg_r.slot_start_ticks    <= cfg_wdata[7:0];
        REG_READ_SAMPLE:   cfg_r.read_sample_ticks   <= cfg_wdata[7:0];
        REG_SLOT:          cfg_r.slot_ticks          <= cfg_wdata;
        REG_RECOVERY:      cfg_r.recovery_ticks      <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  swb_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_op    (head_op),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  swb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_op    (head_op),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

  `SWB_ASSERT_IMP(a_pop_needs_item, head_pop, head_valid, "sequencer took from empty queue")

endmodule

>>> test/single_wire_bus_master_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_bus_master_test
// Self-checking bench for the single-wire bus master. Each tick item is run
// through an in-bench model of the line sequencer when it is accepted. Every
// result item is compared field by field with the oldest outstanding
// prediction. Runs a directed table, then random reset, write and read
// sequences under several timing settings, including zero counts.
// ----------------------------------------------------------------------------
module single_wire_bus_master_test;
  import swb_pkg::*;

  localparam int RAND_ITEMS = 1100;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam swb_res_t RES_QUIET = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b0,
                                     no_presence: 1'b1, read_byte: 8'h00};
  localparam swb_res_t RES_RESET_LOW = '{drive_low: 1'b1, busy_res: 1'b1, done_res: 1'b0,
                                         no_presence: 1'b1, read_byte: 8'h00};
  localparam swb_res_t RES_ANSWERED = '{drive_low: 1'b0, busy_res: 1'b1, done_res: 1'b0,
                                        no_presence: 1'b0, read_byte: 8'h00};
  localparam swb_res_t RES_RELEASED = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b1,
                                        no_presence: 1'b0, read_byte: 8'h00};
  localparam swb_res_t RES_ABSENT = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b1,
                                      no_presence: 1'b1, read_byte: 8'h00};

  typedef enum logic [3:0] {
    LN_IDLE, LN_RESET_LOW, LN_PRESENCE_WAIT, LN_RELEASE_WAIT,
    LN_WR_OPEN, LN_WR_HOLD, LN_WR_RECOVER,
    LN_RD_OPEN, LN_RD_SAMPLE, LN_RD_HOLD, LN_RD_RECOVER
  } line_phase_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       level;
    int         reps;
    bit         typed;
    swb_res_t   res;
  } tick_row_t;

  // all timing registers at one tick for the table
  tick_row_t directed_rows [24] = '{
    '{CMD_TICK,  8'h00, 1'b1, 1,  1'b1, RES_QUIET},
    '{CMD_TICK,  8'hFF, 1'b0, 1,  1'b1, RES_QUIET},
    '{CMD_RESET, 8'h00, 1'b1, 1,  1'b1, RES_RESET_LOW},
    '{CMD_TICK,  8'h00, 1'b0, 1,  1'b1, RES_ANSWERED},
    '{CMD_TICK,  8'h00, 1'b0, 4,  1'b0, RES_QUIET},
    '{CMD_WRITE, 8'h5A, 1'b0, 1,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b1, 1,  1'b1, RES_RELEASED},
    '{CMD_RESET, 8'h00, 1'b1, 1,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b1, 1,  1'b1, RES_ABSENT},
    '{CMD_WRITE, 8'hFF, 1'b1, 23, 1'b0, RES_QUIET},
    '{CMD_WRITE, 8'h00, 1'b0, 23, 1'b0, RES_QUIET},
    '{CMD_READ,  8'h00, 1'b1, 31, 1'b0, RES_QUIET},
    '{CMD_READ,  8'hFF, 1'b0, 31, 1'b0, RES_QUIET},
    '{CMD_WRITE, 8'hA5, 1'b0, 10, 1'b0, RES_QUIET},
    '{CMD_READ,  8'h00, 1'b1, 1,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b0, 12, 1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b0, 2,  1'b0, RES_QUIET},
    '{CMD_READ,  8'h00, 1'b1, 6,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b0, 8,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b1, 17, 1'b0, RES_QUIET},
    '{CMD_RESET, 8'h00, 1'b1, 1,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b0, 1,  1'b0, RES_QUIET},
    '{CMD_RESET, 8'h00, 1'b0, 3,  1'b0, RES_QUIET},
    '{CMD_TICK,  8'h00, 1'b1, 1,  1'b0, RES_QUIET}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swb_in_if  in_ch ();
  swb_out_if out_ch ();

  single_wire_bus_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // line model state and timing mirror
  swb_cfg_t    timing;
  line_phase_t line_phase;
  logic [11:0] tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  shift_reg;
  logic        presence_q;

  swb_res_t line_results_due [$];
  swb_res_t line_results_seen [$];

  int  fail_count;
  int  items_sent;
  int  quiet_cycles;
  bit  sender_calm;
  bit  long_hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic tick_elapsed(input logic [11:0] len);
    tick_cnt = tick_cnt + 12'd1;
    if (tick_cnt >= len) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic swb_res_t predict_line_tick(input logic [1:0] cmd, input logic [7:0] data,
                                                 input logic level);
    swb_res_t r;
    logic     drv;
    logic     fin;
    drv = 1'b0;
    fin = 1'b0;
    if (line_phase == LN_IDLE && cmd != CMD_TICK) begin
      tick_cnt = '0;
      bit_idx = '0;
      case (cmd)
        CMD_RESET: line_phase = LN_RESET_LOW;
        CMD_WRITE: begin
          line_phase = LN_WR_OPEN;
          shift_reg = data;
        end
        default: begin
          line_phase = LN_RD_OPEN;
          shift_reg = '0;
        end
      endcase
    end
    case (line_phase)
      LN_RESET_LOW: begin
        drv = 1'b1;
        if (tick_elapsed(timing.reset_low_ticks)) line_phase = LN_PRESENCE_WAIT;
      end
      LN_PRESENCE_WAIT: begin
        if (tick_elapsed(timing.presence_wait_ticks)) begin
          presence_q = level;
          if (level) begin
            line_phase = LN_IDLE;
            fin = 1'b1;
          end else begin
            line_phase = LN_RELEASE_WAIT;
          end
        end
      end
      LN_RELEASE_WAIT: begin
        if (level) begin
          line_phase = LN_IDLE;
          fin = 1'b1;
        end
      end
      LN_WR_OPEN: begin
        drv = 1'b1;
        if (tick_elapsed({4'd0, timing.slot_start_ticks})) line_phase = LN_WR_HOLD;
      end
      LN_WR_HOLD: begin
        drv = ~shift_reg[0];
        if (tick_elapsed(timing.slot_ticks)) begin
          shift_reg = shift_reg >> 1;
          if (bit_idx == 3'd7) begin
            line_phase = LN_IDLE;
            fin = 1'b1;
          end else begin
            line_phase = LN_WR_RECOVER;
          end
        end
      end
      LN_WR_RECOVER: begin
        if (tick_elapsed({4'd0, timing.recovery_ticks})) begin
          bit_idx = bit_idx + 3'd1;
          line_phase = LN_WR_OPEN;
        end
      end
      LN_RD_OPEN: begin
        drv = 1'b1;
        if (tick_elapsed({4'd0, timing.slot_start_ticks})) line_phase = LN_RD_SAMPLE;
      end
      LN_RD_SAMPLE: begin
        if (tick_elapsed({4'd0, timing.read_sample_ticks})) begin
          shift_reg = {level, shift_reg[7:1]};
          line_phase = LN_RD_HOLD;
        end
      end
      LN_RD_HOLD: begin
        if (tick_elapsed(timing.slot_ticks)) begin
          if (bit_idx == 3'd7) begin
            line_phase = LN_IDLE;
            fin = 1'b1;
          end else begin
            line_phase = LN_RD_RECOVER;
          end
        end
      end
      LN_RD_RECOVER: begin
        if (tick_elapsed({4'd0, timing.recovery_ticks})) begin
          bit_idx = bit_idx + 3'd1;
          line_phase = LN_RD_OPEN;
        end
      end
      default: begin
        line_phase = LN_IDLE;
        tick_cnt = '0;
      end
    endcase
    r.drive_low = drv;
    r.busy_res = (line_phase != LN_IDLE);
    r.done_res = fin;
    r.no_presence = presence_q;
    r.read_byte = shift_reg;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [1:0] pick_start();
    case ($urandom_range(0, 2))
      0: return CMD_RESET;
      1: return CMD_WRITE;
      default: return CMD_READ;
    endcase
  endfunction

  // line held low after reset now and then, so release waits get stretched
  function automatic logic pick_level();
    if (line_phase == LN_RELEASE_WAIT) return ($urandom_range(0, 2) == 0);
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] data, input logic level,
                           input bit typed = 1'b0, input swb_res_t typed_res = '0);
    int       gap;
    swb_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.write_data <= data;
    in_ch.bus_level <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_line_tick(cmd, data, level);
    line_results_due.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic do_op(input logic [1:0] cmd);
    send_tick(cmd, 8'($urandom), pick_level());
    while (line_phase != LN_IDLE) begin
      send_tick(($urandom_range(0, 19) == 0) ? pick_start() : CMD_TICK, 8'($urandom),
                pick_level());
    end
  endtask

  task automatic run_op();
    if ($urandom_range(0, 9) < 8) begin
      do_op(pick_start());
    end else begin
      repeat ($urandom_range(1, 4)) send_tick(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (line_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_RESET_LOW:     timing.reset_low_ticks = value;
      REG_PRESENCE_WAIT: timing.presence_wait_ticks = value;
      REG_SLOT_START:    timing.slot_start_ticks = value[7:0];
      REG_READ_SAMPLE:   timing.read_sample_ticks = value[7:0];
      REG_SLOT:          timing.slot_ticks = value;
      REG_RECOVERY:      timing.recovery_ticks = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [11:0] rst_low, input logic [11:0] pres_wait,
                             input logic [11:0] start, input logic [11:0] sample,
                             input logic [11:0] slot, input logic [11:0] recover);
    write_reg(REG_RESET_LOW, rst_low);
    write_reg(REG_PRESENCE_WAIT, pres_wait);
    write_reg(REG_SLOT_START, start);
    write_reg(REG_READ_SAMPLE, sample);
    write_reg(REG_SLOT, slot);
    write_reg(REG_RECOVERY, recover);
    // unused indexes must leave the timing alone
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void check_result(input swb_res_t want, input swb_res_t got);
    if (got.drive_low !== want.drive_low) begin
      $error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
      fail_count++;
    end
    if (got.busy_res !== want.busy_res) begin
      $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
      fail_count++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
      fail_count++;
    end
    if (got.no_presence !== want.no_presence) begin
      $error("no_presence: expected %0d, got %0d", want.no_presence, got.no_presence);
      fail_count++;
    end
    if (got.read_byte !== want.read_byte) begin
      $error("read_byte: expected %02h, got %02h", want.read_byte, got.read_byte);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      line_results_seen.push_back('{drive_low: out_ch.drive_low, busy_res: out_ch.busy_res,
                                    done_res: out_ch.done_res, no_presence: out_ch.no_presence,
                                    read_byte: out_ch.read_byte});
    end
  end

  always @(negedge clk) begin
    while (line_results_seen.size() != 0) begin
      if (line_results_due.size() == 0) begin
        $error("result item with no prediction outstanding");
        fail_count++;
        void'(line_results_seen.pop_front());
      end else begin
        check_result(line_results_due.pop_front(), line_results_seen.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int n;
    int calm_left;
    int r;
    calm_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        long_hold_req = 1'b0;
        n = LONG_HOLD;
      end else if (calm_left > 0) begin
        out_ch.ready <= 1'b1;
        calm_left--;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          calm_left = $urandom_range(50, 300);
          out_ch.ready <= 1'b1;
          n = 1;
        end else if (r < 70) begin
          out_ch.ready <= 1'b1;
          n = $urandom_range(1, 4);
        end else if (r < 97) begin
          out_ch.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          n = $urandom_range(10, 30);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int rand_first;
    int phase_first;
    fail_count = 0;
    items_sent = 0;
    quiet_cycles = 0;
    sender_calm = 1'b0;
    long_hold_req = 1'b0;
    timing = '{reset_low_ticks: 12'd600, presence_wait_ticks: 12'd60, slot_start_ticks: 8'd2,
               read_sample_ticks: 8'd2, slot_ticks: 12'd60, recovery_ticks: 8'd1};
    line_phase = LN_IDLE;
    tick_cnt = '0;
    bit_idx = '0;
    shift_reg = '0;
    presence_q = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RESET_LOW;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.write_data <= '0;
    in_ch.bus_level <= 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].level,
                directed_rows[i].typed, directed_rows[i].res);
      for (int k = 1; k < directed_rows[i].reps; k++) begin
        send_tick(CMD_TICK, directed_rows[i].data, directed_rows[i].level);
      end
    end
    settle();

    long_hold_req = 1'b1;
    rand_first = items_sent;
    while (items_sent - rand_first < RAND_ITEMS) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      load_timing(12'($urandom_range(1, 8)), 12'($urandom_range(1, 8)),
                  {4'($urandom), 8'($urandom_range(1, 4))},
                  {4'($urandom), 8'($urandom_range(1, 4))},
                  12'($urandom_range(1, 6)),
                  {4'($urandom), 8'($urandom_range(1, 3))});
      phase_first = items_sent;
      while (items_sent - phase_first < PHASE_ITEMS) run_op();
      settle();
    end

    // zero counts act as one tick
    sender_calm = 1'b0;
    load_timing(12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000);
    repeat (12) run_op();
    settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/swb_pkg.sv
rtl/core/swb_in_if.sv
rtl/core/swb_out_if.sv
rtl/core/swb_front.sv
rtl/core/swb_back.sv
rtl/core/single_wire_bus_master.sv
test/single_wire_bus_master_test.sv
